FILE: rtl/kedar_pkg.sv
package kedar_pkg;

	localparam int KEYS_PER_ROW = 10;
	localparam int TS_W         = 48;
	localparam int CFG_W        = 24;
	localparam int KEY_W        = 7;
	localparam int POS_W        = 4;

	// row split by reciprocal multiply: exact for every 7-bit key number
	localparam int DIV_SH  = 11;
	localparam int DIV_MUL = (2**DIV_SH + KEYS_PER_ROW - 1) / KEYS_PER_ROW;
	localparam int PROD_W  = KEY_W + DIV_SH + 1;

	localparam logic [CFG_W-1:0] DELAY_RST  = CFG_W'(400000);
	localparam logic [CFG_W-1:0] PERIOD_RST = CFG_W'(45000);

	// register index taken from paddr[2]
	localparam logic REG_DELAY  = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		CMD_POLL   = 2'd0,
		CMD_EVENT  = 2'd1,
		CMD_DETACH = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [7:0]      event_code;
		logic            key_repeats;
		logic [TS_W-1:0] now_us;
	} item_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             pressed;
	} res_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} pos_t;

	// zero-based key number to matrix position, low 4 bits of each
	function automatic pos_t key_split(input logic [KEY_W-1:0] key);
		logic [PROD_W-1:0] prod;
		logic [KEY_W-1:0]  quo;
		logic [KEY_W-1:0]  rem;
		pos_t              p;
		prod  = PROD_W'(key) * PROD_W'(DIV_MUL);
		quo   = prod[DIV_SH +: KEY_W];
		rem   = key - quo * KEY_W'(KEYS_PER_ROW);
		p.row = quo[POS_W-1:0];
		p.col = rem[POS_W-1:0];
		return p;
	endfunction

endpackage

FILE: rtl/kedar_hold.sv
module kedar_hold
	import kedar_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  logic             step,
	input  logic [CFG_W-1:0] delay_us,
	input  logic [CFG_W-1:0] period_us,
	output res_t             res
);

	logic             active_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic [TS_W-1:0]  deadline_q;

	logic [KEY_W-1:0] num;
	logic [KEY_W-1:0] key;
	pos_t             pos;
	logic             press;
	logic             due;
	logic [TS_W-1:0]  dl_delay;
	logic [TS_W-1:0]  dl_period;

	logic             active_d;
	logic             load_key;
	logic             load_dl;
	logic [TS_W-1:0]  deadline_d;

	assign num       = item.event_code[KEY_W-1:0];
	assign key       = num - KEY_W'(1);
	assign pos       = key_split(key);
	assign press     = item.event_code[7];
	assign due       = item.now_us >= deadline_q;
	assign dl_delay  = item.now_us + TS_W'(delay_us);
	assign dl_period = item.now_us + TS_W'(period_us);

	always_comb begin
		res        = '0;
		active_d   = active_q;
		load_key   = 1'b0;
		load_dl    = 1'b0;
		deadline_d = dl_period;
		unique case (item.cmd)
			CMD_POLL: begin
				if (active_q && due) begin
					res.hit     = 1'b1;
					res.row     = row_q;
					res.col     = col_q;
					res.pressed = 1'b1;
					load_dl     = 1'b1;
				end
			end
			CMD_DETACH: begin
				active_d = 1'b0;
			end
			CMD_EVENT: begin
				if (num != '0) begin
					res.hit     = 1'b1;
					res.row     = pos.row;
					res.col     = pos.col;
					res.pressed = press;
					if (press) begin
						active_d = item.key_repeats;
						if (item.key_repeats) begin
							load_key   = 1'b1;
							load_dl    = 1'b1;
							deadline_d = dl_delay;
						end
					end else if (active_q && pos.row == row_q && pos.col == col_q) begin
						active_d = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			deadline_q <= '0;
		end else if (step) begin
			active_q <= active_d;
			if (load_key) begin
				row_q <= pos.row;
				col_q <= pos.col;
			end
			if (load_dl) begin
				deadline_q <= deadline_d;
			end
		end
	end

endmodule

FILE: rtl/key_event_decode_autorepeat.sv
// Path: a request is held in the input register and its report in the output register.
// Throughput: one request per cycle unless a report meets a full output register not taken;
//   the hold state is read and updated between the input and result registers.
// Reset: arst_n clears both valid flags, the hold state and the deadline, and
//   loads the repeat delay (400000 us) and period (45000 us) registers.
module key_event_decode_autorepeat
	import kedar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave side: requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // event_code[7:0], key_repeats[8], now_us[56:9], zero
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	// master side: key reports
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // row[3:0], col[7:4], pressed[8], zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers: delay at 0x0, period at 0x4.
	logic [CFG_W-1:0] delay_q;
	logic [CFG_W-1:0] period_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_PERIOD) ? 32'(period_q) : 32'(delay_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_DELAY) begin
				delay_q <= pwdata[CFG_W-1:0];
			end else begin
				period_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Input register: hold one request until the hold logic has taken it.
	logic  v_s1;
	item_t item_s1;
	logic  s_acc;
	logic  adv;
	res_t  res;

	// Output register, doubling as the skid stage toward m_axis.
	logic             out_v_q;
	logic [POS_W-1:0] out_row_q;
	logic [POS_W-1:0] out_col_q;
	logic             out_pr_q;

	// Advance the input stage unless it makes a report and the output
	// register is still full and not being taken this cycle.
	assign adv           = v_s1 && (!res.hit || !out_v_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_s1.cmd         <= s_axis_tuser;
			item_s1.event_code  <= s_axis_tdata[7:0];
			item_s1.key_repeats <= s_axis_tdata[8];
			item_s1.now_us      <= s_axis_tdata[56:9];
		end
	end

	// Decode, deadline check and hold update all happen in this one step.
	kedar_hold u_hold (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.step      (adv),
		.delay_us  (delay_q),
		.period_us (period_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && res.hit) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.hit) begin
			out_row_q <= res.row;
			out_col_q <= res.col;
			out_pr_q  <= res.pressed;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {7'b0, out_pr_q, out_col_q, out_row_q};

endmodule

FILE: rtl/kedar_chk.sv
module kedar_chk
	import kedar_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        pready
);

	// no report is pending while reset is asserted
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("report valid during reset");

	// with the output register empty the block always takes a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request stalled with output empty");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// a stalled report stays and holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report dropped or changed while stalled");

endmodule

bind key_event_decode_autorepeat kedar_chk u_kedar_chk (.*);
